### rtl/pidc_pkg.sv
// Shared widths, register indexes and command codes of the clamped PID unit.
`default_nettype none
package pidc_pkg;

  localparam int GAIN_W  = 16;  // Q8.8 gains
  localparam int RATE_W  = 16;  // supplied derivative
  localparam int DRIVE_W = 16;  // controller output
  localparam int ILIM_W  = 23;  // integrator limit
  localparam int DLIM_W  = 15;  // drive limit
  localparam int CFG_W   = 23;  // widest register
  localparam int CIDX_W  = 3;

  localparam logic [1:0] CMD_STEP_DIFF = 2'd0;
  localparam logic [1:0] CMD_STEP_RATE = 2'd1;
  localparam logic [1:0] CMD_CLEAR     = 2'd2;
  localparam logic [1:0] CMD_PRESET    = 2'd3;

  typedef enum logic [CIDX_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_DRIVE_LIMIT = 3'd4
  } reg_idx_t;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 16'sd256;

endpackage
`default_nettype wire

### rtl/pidc_integ_sat.sv
// Integrator update: add error, saturate to the integrator width, clamp to a nonzero limit.
`default_nettype none
module pidc_integ_sat import pidc_pkg::*; #(
  parameter int INTEG_WIDTH = 24,
  parameter int ERR_WIDTH   = 16
) (
  input  wire logic signed [INTEG_WIDTH-1:0] integ,
  input  wire logic signed [ERR_WIDTH-1:0]   err,
  input  wire logic        [ILIM_W-1:0]      limit,
  output logic signed      [INTEG_WIDTH-1:0] integ_next,
  output logic                               hit
);

  localparam int SW = ((INTEG_WIDTH > ERR_WIDTH) ? INTEG_WIDTH : ERR_WIDTH) + 1;
  localparam int CW = ((INTEG_WIDTH > ILIM_W) ? INTEG_WIDTH : ILIM_W) + 1;
  localparam logic signed [SW-1:0] SAT_HI =
    $signed({{(SW-INTEG_WIDTH+1){1'b0}}, {(INTEG_WIDTH-1){1'b1}}});
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  logic signed [SW-1:0]          sum;
  logic signed [INTEG_WIDTH-1:0] sat_v;
  logic                          sat_hit;
  logic signed [CW-1:0]          v_w;
  logic signed [CW-1:0]          lim_w;
  logic signed [CW-1:0]          nlim_w;

  always_comb begin
    sum     = SW'(integ) + SW'(err);
    sat_hit = 1'b0;
    if (sum > SAT_HI) begin
      sat_v   = INTEG_WIDTH'(SAT_HI);
      sat_hit = 1'b1;
    end else if (sum < SAT_LO) begin
      sat_v   = INTEG_WIDTH'(SAT_LO);
      sat_hit = 1'b1;
    end else begin
      sat_v = INTEG_WIDTH'(sum);
    end

    // limit above the saturation range never bites
    v_w    = CW'(sat_v);
    lim_w  = $signed(CW'(limit));
    nlim_w = -lim_w;
    hit    = sat_hit;
    if (limit != '0 && v_w > lim_w) begin
      integ_next = INTEG_WIDTH'(lim_w);
      hit        = 1'b1;
    end else if (limit != '0 && v_w < nlim_w) begin
      integ_next = INTEG_WIDTH'(nlim_w);
      hit        = 1'b1;
    end else begin
      integ_next = sat_v;
    end
  end

endmodule
`default_nettype wire

### rtl/pidc_drive_clamp.sv
// Drive shaping: floor shift of the gain sum, then clamp or 16-bit saturation.
`default_nettype none
module pidc_drive_clamp import pidc_pkg::*; #(
  parameter int SUM_WIDTH      = 50,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire logic signed [SUM_WIDTH-1:0] sum,
  input  wire logic        [DLIM_W-1:0]    limit,
  output logic signed      [DRIVE_W-1:0]   drive,
  output logic                             hit
);

  localparam logic signed [SUM_WIDTH-1:0] SAT_HI =
    $signed({{(SUM_WIDTH-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}});
  localparam logic signed [SUM_WIDTH-1:0] SAT_LO = ~SAT_HI;

  logic signed [SUM_WIDTH-1:0] shifted;
  logic signed [SUM_WIDTH-1:0] hi;
  logic signed [SUM_WIDTH-1:0] lo;
  logic signed [SUM_WIDTH-1:0] lim_w;

  always_comb begin
    shifted = sum >>> GAIN_FRAC_BITS;
    lim_w   = $signed(SUM_WIDTH'(limit));
    if (limit != '0) begin
      hi = lim_w;
      lo = -lim_w;
    end else begin
      hi = SAT_HI;
      lo = SAT_LO;
    end
    hit = 1'b0;
    if (shifted > hi) begin
      drive = DRIVE_W'(hi);
      hit   = 1'b1;
    end else if (shifted < lo) begin
      drive = DRIVE_W'(lo);
      hit   = 1'b1;
    end else begin
      drive = DRIVE_W'(shifted);
    end
  end

endmodule
`default_nettype wire

### rtl/pid_controller_clamped_unit.sv
// Top level of the clamped positional PID unit: registers, pipeline and state.
//
// Input channel (in_valid / in_stall) carries cmd, err_in, rate_in and
// integ_preset; a transfer happens on a rising edge with in_valid high and
// in_stall low. Step commands (0: difference derivative, 1: rate_in as
// derivative) give one result on the output channel (out_valid / out_stall):
// drive plus the two clamp flags. Clear (2) and preset (3) only touch state
// and give no result.
// Pipeline: input register, integrator update + derivative, three gain
// products, then sum / floor shift / drive clamp into the output register.
// One item per cycle is sustained while the receiver does not stall; the
// integrator feedback loop closes through the integ register alone.
// When the receiver stalls, the result holds in the output register and the
// stages behind it keep filling until full; only then is in_stall raised.
// Configuration: cfg_valid / cfg_ready (always ready), cfg_index picks the
// register (gain_p, gain_i, gain_d, integ_limit, drive_limit), cfg_data is
// the value; unknown indexes are dropped. Write only while idle.
// rst (synchronous) empties the pipeline, clears integrator and last error
// and restores register defaults (gain_p = 1.0, everything else zero).
`default_nettype none
module pid_controller_clamped_unit import pidc_pkg::*; #(
  parameter int ERR_WIDTH      = 16,
  parameter int INTEG_WIDTH    = 24,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic        [CIDX_W-1:0]      cfg_index,
  input  wire logic        [CFG_W-1:0]       cfg_data,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic        [1:0]             cmd,
  input  wire logic signed [ERR_WIDTH-1:0]   err_in,
  input  wire logic signed [RATE_W-1:0]      rate_in,
  input  wire logic signed [INTEG_WIDTH-1:0] integ_preset,
  // results
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed      [DRIVE_W-1:0]     drive,
  output logic                               drive_clamped,
  output logic                               integ_clamped
);

  localparam int DW  = ((ERR_WIDTH + 1) > RATE_W) ? (ERR_WIDTH + 1) : RATE_W;
  localparam int PPW = GAIN_W + ERR_WIDTH;
  localparam int IPW = GAIN_W + INTEG_WIDTH;
  localparam int DPW = GAIN_W + DW;
  localparam int MW1 = (PPW > IPW) ? PPW : IPW;
  localparam int MW  = (MW1 > DPW) ? MW1 : DPW;
  localparam int SUMW = MW + 2;

  // configuration registers
  logic signed [GAIN_W-1:0] gain_p;
  logic signed [GAIN_W-1:0] gain_i;
  logic signed [GAIN_W-1:0] gain_d;
  logic        [ILIM_W-1:0] integ_limit;
  logic        [DLIM_W-1:0] drive_limit;

  // controller state
  logic signed [INTEG_WIDTH-1:0] integ;
  logic signed [ERR_WIDTH-1:0]   last_error;

  // input register
  logic                          v0;
  logic [1:0]                    s0_cmd;
  logic signed [ERR_WIDTH-1:0]   s0_err;
  logic signed [RATE_W-1:0]      s0_rate;
  logic signed [INTEG_WIDTH-1:0] s0_preset;

  // integrator / derivative stage
  logic                          v1;
  logic signed [ERR_WIDTH-1:0]   s1_err;
  logic signed [INTEG_WIDTH-1:0] s1_integ;
  logic signed [DW-1:0]          s1_deriv;
  logic                          s1_ihit;

  // product stage
  logic                          v2;
  logic signed [PPW-1:0]         s2_pp;
  logic signed [IPW-1:0]         s2_ip;
  logic signed [DPW-1:0]         s2_dp;
  logic                          s2_ihit;

  logic rdy0, rdy1, rdy2, adv3;
  logic is_step;

  logic signed [INTEG_WIDTH-1:0] integ_next;
  logic                          integ_hit;
  logic signed [DW-1:0]          deriv_next;
  logic signed [SUMW-1:0]        sum_next;
  logic signed [DRIVE_W-1:0]     drive_next;
  logic                          drive_hit;

  // stall chain: a stage takes a transfer when empty or when it empties itself
  assign adv3      = !out_valid || !out_stall;
  assign rdy2      = !v2 || adv3;
  assign rdy1      = !v1 || rdy2;
  assign rdy0      = !v0 || rdy1;
  assign in_stall  = !rdy0;
  assign cfg_ready = 1'b1;

  assign is_step = (s0_cmd == CMD_STEP_DIFF) || (s0_cmd == CMD_STEP_RATE);

  pidc_integ_sat #(
    .INTEG_WIDTH (INTEG_WIDTH),
    .ERR_WIDTH   (ERR_WIDTH)
  ) u_integ (
    .integ      (integ),
    .err        (s0_err),
    .limit      (integ_limit),
    .integ_next (integ_next),
    .hit        (integ_hit)
  );

  always_comb begin
    if (s0_cmd == CMD_STEP_DIFF) begin
      deriv_next = DW'(s0_err) - DW'(last_error);
    end else begin
      deriv_next = DW'(s0_rate);
    end
  end

  assign sum_next = SUMW'(s2_pp) + SUMW'(s2_ip) + SUMW'(s2_dp);

  pidc_drive_clamp #(
    .SUM_WIDTH      (SUMW),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_drive (
    .sum   (sum_next),
    .limit (drive_limit),
    .drive (drive_next),
    .hit   (drive_hit)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p      <= GAIN_P_RST;
      gain_i      <= '0;
      gain_d      <= '0;
      integ_limit <= '0;
      drive_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_P:      gain_p      <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_I:      gain_i      <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_D:      gain_d      <= $signed(cfg_data[GAIN_W-1:0]);
        REG_INTEG_LIMIT: integ_limit <= cfg_data[ILIM_W-1:0];
        REG_DRIVE_LIMIT: drive_limit <= cfg_data[DLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits and state
  always_ff @(posedge clk) begin
    if (rst) begin
      v0         <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      out_valid  <= 1'b0;
      integ      <= '0;
      last_error <= '0;
    end else begin
      if (rdy0) v0 <= in_valid;
      if (rdy1) v1 <= v0 && is_step;
      if (rdy2) v2 <= v1;
      if (adv3) out_valid <= v2;
      if (v0 && rdy1) begin
        case (s0_cmd)
          CMD_CLEAR: begin
            integ      <= '0;
            last_error <= '0;
          end
          CMD_PRESET: integ <= s0_preset;
          default: begin
            integ      <= integ_next;
            last_error <= s0_err;
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      s0_cmd    <= cmd;
      s0_err    <= err_in;
      s0_rate   <= rate_in;
      s0_preset <= integ_preset;
    end
    if (rdy1 && v0) begin
      s1_err   <= s0_err;
      s1_integ <= integ_next;
      s1_deriv <= deriv_next;
      s1_ihit  <= integ_hit;
    end
    if (rdy2 && v1) begin
      s2_pp   <= PPW'(gain_p) * PPW'(s1_err);
      s2_ip   <= IPW'(gain_i) * IPW'(s1_integ);
      s2_dp   <= DPW'(gain_d) * DPW'(s1_deriv);
      s2_ihit <= s1_ihit;
    end
    if (adv3 && v2) begin
      drive         <= drive_next;
      drive_clamped <= drive_hit;
      integ_clamped <= s2_ihit;
    end
  end

endmodule
`default_nettype wire

### tb/pid_controller_clamped_unit_tb.sv
// Self-checking testbench for the clamped positional PID unit.
`timescale 1ns / 100ps
`default_nettype none
module pid_controller_clamped_unit_tb import pidc_pkg::*; ();

  // Widths of the unit as built (default parameters)
  localparam int ERR_W   = 16;
  localparam int INTEG_W = 24;
  localparam int FRAC    = 8;

  localparam longint INTEG_HI = (longint'(1) <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_LO = -INTEG_HI - 1;
  localparam longint DRIVE_HI = (longint'(1) <<< (DRIVE_W - 1)) - 1;
  localparam longint DRIVE_LO = -DRIVE_HI - 1;

  // Register indexes past the end of the map; writes there must be dropped
  localparam logic [CIDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CIDX_W-1:0] REG_SPARE    = 3'd7;

  localparam int PIPE_LAT    = 3;       // input transfer to out_valid
  localparam int DRAIN       = 4 * PIPE_LAT;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 200;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      drive_clamped;
    logic                      integ_clamped;
  } pid_out_t;

  typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [1:0]                op;
    logic signed [ERR_W-1:0]   err;
    logic signed [RATE_W-1:0]  rate;
    logic signed [INTEG_W-1:0] preset;
    logic [CIDX_W-1:0]         idx;
    logic [CFG_W-1:0]          val;
    bit                        typed;   // want holds a hand-worked result
    pid_out_t                  want;
  } stim_row_t;

  // ---------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;
  logic cfg_valid, cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic in_valid, in_stall;
  logic [1:0] cmd;
  logic signed [ERR_W-1:0]   err_in;
  logic signed [RATE_W-1:0]  rate_in;
  logic signed [INTEG_W-1:0] integ_preset;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DRIVE_W-1:0] drive;
  logic drive_clamped, integ_clamped;

  always #5 clk = ~clk;

  pid_controller_clamped_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .err_in        (err_in),
    .rate_in       (rate_in),
    .integ_preset  (integ_preset),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive         (drive),
    .drive_clamped (drive_clamped),
    .integ_clamped (integ_clamped)
  );

  // ---------------------------------------------------------------------
  // Controller model: own copy of registers and state
  // ---------------------------------------------------------------------
  logic signed [GAIN_W-1:0]  kp, ki, kd;
  logic [ILIM_W-1:0]         ilim;
  logic [DLIM_W-1:0]         dlim;
  logic signed [INTEG_W-1:0] acc;
  logic signed [ERR_W-1:0]   prev_err;

  pid_out_t pending_drive[$];   // results still owed by the unit, oldest first

  int faults, cycles, n_items, n_results, n_clear, n_preset, n_dhit, n_ihit;
  bit jitter;                   // random idling on both sides when set

  // One controller step; returns 1 when the command yields a result.
  function automatic bit pid_advance(input logic [1:0] op,
                                     input logic signed [ERR_W-1:0] e,
                                     input logic signed [RATE_W-1:0] r,
                                     input logic signed [INTEG_W-1:0] pre,
                                     output pid_out_t res);
    longint s, d, total, y;
    bit ih, dh;
    ih  = 1'b0;
    dh  = 1'b0;
    res = '0;
    if (op == CMD_CLEAR) begin
      acc      = '0;
      prev_err = '0;
      return 1'b0;
    end
    if (op == CMD_PRESET) begin
      acc = pre;                // limit deliberately not applied
      return 1'b0;
    end
    // integrator: saturate to its width, then the optional symmetric clamp
    s = longint'(acc) + longint'(e);
    if (s > INTEG_HI) begin s = INTEG_HI; ih = 1'b1; end
    else if (s < INTEG_LO) begin s = INTEG_LO; ih = 1'b1; end
    if (ilim != 0) begin
      if (s > longint'(ilim)) begin s = longint'(ilim); ih = 1'b1; end
      else if (s < -longint'(ilim)) begin s = -longint'(ilim); ih = 1'b1; end
    end
    acc = s[INTEG_W-1:0];
    d = (op == CMD_STEP_DIFF) ? longint'(e) - longint'(prev_err) : longint'(r);
    total = longint'(kp) * longint'(e) + longint'(ki) * longint'(acc)
          + longint'(kd) * d;
    y = total >>> FRAC;         // floor
    if (dlim != 0) begin
      if (y > longint'(dlim)) begin y = longint'(dlim); dh = 1'b1; end
      else if (y < -longint'(dlim)) begin y = -longint'(dlim); dh = 1'b1; end
    end else begin
      if (y > DRIVE_HI) begin y = DRIVE_HI; dh = 1'b1; end
      else if (y < DRIVE_LO) begin y = DRIVE_LO; dh = 1'b1; end
    end
    prev_err = e;
    res.drive         = y[DRIVE_W-1:0];
    res.drive_clamped = dh;
    res.integ_clamped = ih;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------
  stim_row_t script[$];

  function automatic void step_row(logic [1:0] op, int e, int r, int pre,
                                   bit typed, int drv, bit dh, bit ih);
    stim_row_t row;
    row = '{kind: ROW_ITEM, op: op, err: ERR_W'(e), rate: RATE_W'(r),
            preset: INTEG_W'(pre), idx: '0, val: '0, typed: typed,
            want: '{drive: DRIVE_W'(drv), drive_clamped: dh,
            integ_clamped: ih}};
    script.push_back(row);
  endfunction

  function automatic void reg_row(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] v);
    stim_row_t row;
    row = '{kind: ROW_REG, op: CMD_STEP_DIFF, err: '0, rate: '0, preset: '0,
            idx: idx, val: v, typed: 1'b0, want: '0};
    script.push_back(row);
  endfunction

  function automatic void build_script();
    // Reset settings: unity P gain, no I or D, no limits -> drive equals err
    step_row(CMD_STEP_DIFF,      0,      0,        0, 1,      0, 0, 0);
    step_row(CMD_STEP_DIFF,  32767,      0,        0, 1,  32767, 0, 0);
    step_row(CMD_STEP_DIFF, -32768,      0,        0, 1, -32768, 0, 0);
    step_row(CMD_STEP_RATE,    100, -32768,        0, 1,    100, 0, 0);
    // integrator preset to the rails, next step saturates it
    step_row(CMD_PRESET,         0,      0,  8388607, 0,      0, 0, 0);
    step_row(CMD_STEP_DIFF,      1,      0,        0, 1,      1, 0, 1);
    step_row(CMD_PRESET,         0,      0, -8388608, 0,      0, 0, 0);
    step_row(CMD_STEP_RATE,     -1,  32767,        0, 1,     -1, 0, 1);
    step_row(CMD_CLEAR,      -1234,   4321,       -1, 0,      0, 0, 0);
    step_row(CMD_STEP_DIFF,      7,      0,        0, 1,      7, 0, 0);
    // output clamp at 100; a value right on the limit is not a hit
    reg_row(REG_DRIVE_LIMIT, 23'd100);
    step_row(CMD_STEP_DIFF,  32767,      0,        0, 1,    100, 1, 0);
    step_row(CMD_STEP_DIFF, -32768,      0,        0, 1,   -100, 1, 0);
    step_row(CMD_STEP_DIFF,    100,      0,        0, 1,    100, 0, 0);
    // integrator clamp at 50 (integrator sits at 106 here), no drive limit
    reg_row(REG_INTEG_LIMIT, 23'd50);
    reg_row(REG_DRIVE_LIMIT, 23'd0);
    step_row(CMD_STEP_DIFF,      0,      0,        0, 1,      0, 0, 1);
    step_row(CMD_STEP_DIFF,   -101,      0,        0, 1,   -101, 0, 1);
    // extreme gains and widest limits, junk above the gain field
    reg_row(REG_GAIN_P, 23'h7F8000);
    reg_row(REG_GAIN_I, 23'h007FFF);
    reg_row(REG_GAIN_D, 23'h557FFF);
    reg_row(REG_INTEG_LIMIT, 23'h7FFFFF);
    reg_row(REG_DRIVE_LIMIT, 23'h7FFFFF);
    reg_row(REG_SPARE, 23'h000000);     // must leave every register alone
    step_row(CMD_STEP_DIFF,  32767,      0,        0, 0,      0, 0, 0);
    step_row(CMD_STEP_DIFF, -32768,      0,        0, 0,      0, 0, 0);
    step_row(CMD_STEP_RATE, -32768, -32768,        0, 0,      0, 0, 0);
    step_row(CMD_PRESET,         0,      0, -8388608, 0,      0, 0, 0);
    step_row(CMD_STEP_DIFF, -32768,      0,        0, 0,      0, 0, 0);
    step_row(CMD_CLEAR,          0,      0,        0, 0,      0, 0, 0);
    step_row(CMD_STEP_RATE,      0,  32767,        0, 0,      0, 0, 0);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus tasks
  // ---------------------------------------------------------------------
  // Offer one item, hold it through stalls, account for it on transfer.
  task automatic put_item(input logic [1:0] op, input logic signed [ERR_W-1:0] e,
                          input logic signed [RATE_W-1:0] r,
                          input logic signed [INTEG_W-1:0] pre,
                          input bit typed, input pid_out_t want);
    int gap;
    pid_out_t got;
    gap = (jitter && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    cmd          <= op;
    err_in       <= e;
    rate_in      <= r;
    integ_preset <= pre;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    if (op == CMD_CLEAR) n_clear++;
    if (op == CMD_PRESET) n_preset++;
    if (pid_advance(op, e, r, pre, got)) begin
      n_dhit += got.drive_clamped;
      n_ihit += got.integ_clamped;
      pending_drive.push_back(typed ? want : got);
    end
  endtask

  // Let the unit go idle: every result in, then a further drain wait, since
  // clear and preset leave nothing to wait on.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_GAIN_P:      kp   = v[GAIN_W-1:0];
      REG_GAIN_I:      ki   = v[GAIN_W-1:0];
      REG_GAIN_D:      kd   = v[GAIN_W-1:0];
      REG_INTEG_LIMIT: ilim = v[ILIM_W-1:0];
      REG_DRIVE_LIMIT: dlim = v[DLIM_W-1:0];
      default: ;                // unmapped index, dropped
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3, 4, 5: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [ERR_W-1:0] pick_err();
    case ($urandom_range(0, 9))
      0:          return 16'sh8000;
      1:          return 16'sh7FFF;
      2, 3, 4, 5: return 16'($signed($urandom_range(0, 600)) - 300);
      default:    return 16'($urandom);
    endcase
  endfunction

  // Fresh settings for a random phase; the first two sit on the extremes.
  // Bits above each field are filled with junk so that masking is exercised.
  task automatic load_settings(input int phase);
    logic [CFG_W-1:0] v;
    int sel;
    sel = (phase < 2) ? phase : 2;
    v = 23'($urandom);
    v[GAIN_W-1:0] = (sel == 0) ? 16'h7FFF : (sel == 1) ? 16'h8000 : pick_gain();
    write_reg(REG_GAIN_P, v);
    v = 23'($urandom);
    v[GAIN_W-1:0] = (sel == 0) ? 16'h7FFF : (sel == 1) ? 16'h8000 : pick_gain();
    write_reg(REG_GAIN_I, v);
    v = 23'($urandom);
    v[GAIN_W-1:0] = (sel == 0) ? 16'h7FFF : (sel == 1) ? 16'h8000 : pick_gain();
    write_reg(REG_GAIN_D, v);
    case ((sel == 2) ? $urandom_range(0, 3) : sel)
      0:       v = 23'h7FFFFF;
      1:       v = '0;
      2:       v = 23'($urandom_range(1, 2000));
      default: v = 23'($urandom);
    endcase
    write_reg(REG_INTEG_LIMIT, v);
    case ((sel == 2) ? $urandom_range(0, 3) : sel)
      0:       v = 23'h7FFF;
      1:       v = '0;
      2:       v = 23'($urandom_range(1, 500));
      default: v = 23'($urandom);
    endcase
    v[CFG_W-1:DLIM_W] = 8'($urandom);
    write_reg(REG_DRIVE_LIMIT, v);
    if ($urandom_range(0, 1) == 0)
      write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE)), 23'($urandom));
  endtask

  // ---------------------------------------------------------------------
  // Result side: out_stall raised at random, in bursts over consecutive cycles
  // ---------------------------------------------------------------------
  int stall_run;

  always @(negedge clk) begin
    if (rst || !jitter) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic flag_fault(input string what);
    faults++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Each result transfer is matched against the oldest outstanding one
  always @(posedge clk) begin
    pid_out_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (pending_drive.size() == 0) begin
        flag_fault($sformatf("unexpected result drive=%0d", drive));
      end else begin
        exp_r = pending_drive.pop_front();
        if (drive !== exp_r.drive)
          flag_fault($sformatf("drive %0d, expected %0d", drive, exp_r.drive));
        if (drive_clamped !== exp_r.drive_clamped)
          flag_fault($sformatf("drive_clamped %b, expected %b",
                               drive_clamped, exp_r.drive_clamped));
        if (integ_clamped !== exp_r.integ_clamped)
          flag_fault($sformatf("integ_clamped %b, expected %b",
                               integ_clamped, exp_r.integ_clamped));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycles, pending_drive.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [1:0] op;
    int pick;
    logic signed [RATE_W-1:0]  r;
    logic signed [INTEG_W-1:0] pre;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = CMD_STEP_DIFF;
    err_in = '0;
    rate_in = '0;
    integ_preset = '0;
    faults = 0;
    n_items = 0;
    n_results = 0;
    n_clear = 0;
    n_preset = 0;
    n_dhit = 0;
    n_ihit = 0;
    jitter = 1'b0;
    // model reset state
    kp = GAIN_P_RST;
    ki = '0;
    kd = '0;
    ilim = '0;
    dlim = '0;
    acc = '0;
    prev_err = '0;
    build_script();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed walk, with some idling mixed in
    jitter = 1'b1;
    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        settle();
        write_reg(script[i].idx, script[i].val);
      end else begin
        put_item(script[i].op, script[i].err, script[i].rate, script[i].preset,
                 script[i].typed, script[i].want);
      end
    end

    // Random phases; idling is chosen at random per phase and is off in the last one
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      load_settings(p);
      jitter = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        op = (pick < 45) ? CMD_STEP_DIFF : (pick < 90) ? CMD_STEP_RATE :
             (pick < 95) ? CMD_CLEAR : CMD_PRESET;
        r = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                        : 16'($signed($urandom_range(0, 600)) - 300);
        case ($urandom_range(0, 4))
          0:       pre = 24'sh7FFFFF;
          1:       pre = 24'sh800000;
          2:       pre = 24'($signed($urandom_range(0, 4000)) - 2000);
          default: pre = 24'($urandom);
        endcase
        put_item(op, pick_err(), r, pre, 1'b0, '0);
      end
    end

    settle();
    $display("Covered %0d items (%0d clears, %0d presets) over %0d register settings",
             n_items, n_clear, n_preset, RAND_PHASES + 4);
    $display("Checked %0d results: %0d with drive clamped, %0d with integrator clamped",
             n_results, n_dhit, n_ihit);
    if (faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", faults);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

### pid_controller_clamped_unit.f
rtl/pidc_pkg.sv
rtl/pidc_integ_sat.sv
rtl/pidc_drive_clamp.sv
rtl/pid_controller_clamped_unit.sv
tb/pid_controller_clamped_unit_tb.sv
